>>> hdl/tgq_pkg.sv
`default_nettype none

package tgq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int ID_SPACE_DEF    = 1024;
  localparam int TEAM_COUNT_DEF  = 256;

  localparam int ID_W     = 10;
  localparam int TEAM_W   = 8;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int QCOUNT_W = 7;
  localparam int BUF_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENQ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEQ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   element_id;
    logic [TEAM_W-1:0] team_number;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]     head_element;
    logic                head_valid;
    logic [STATUS_W-1:0] status;
    logic [QCOUNT_W-1:0] queue_count;
  } result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   element_id;
    logic [TEAM_W-1:0] team_number;
    logic              id_ok;
    logic              load_ok;
  } cmd_t;

  function automatic logic id_in_space(input logic [ID_W-1:0] id, input int space);
    return int'(id) < space;
  endfunction

endpackage

`default_nettype wire

>>> hdl/team_grouped_queue_top.sv
`default_nettype none

// Team queue of element ids: a load request maps an id to a team, an enqueue places the id
// just behind the last queued member of its team (or at the tail), a dequeue returns the
// head and a clear empties the queue and sets every team back to zero. Requests are taken
// through a two-entry input queue and results leave through a two-entry result queue, so
// each side may stall freely. Loads, clears and rejected requests finish in the idle state of
// the back end; dequeues and enqueues take longer, paced by the single read port of the
// queue store, which every queued entry passes through while the queue is scanned and
// shifted. After reset and after every clear the team table is swept to zero one entry a
// cycle, all ID_SPACE entries (1024 by default), and full stays high until the sweep ends.
module team_grouped_queue_top
  import tgq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_SPACE    = ID_SPACE_DEF,
  parameter int TEAM_COUNT  = TEAM_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic    front_full;
  logic    sweeping;
  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_pop;
  logic    res_push;
  logic    res_full;
  result_t res;

  assign full = front_full || sweeping;

  tgq_front #(
    .ID_SPACE   (ID_SPACE),
    .TEAM_COUNT (TEAM_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push && !full),
    .full      (front_full),
    .item      (item),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  tgq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_SPACE    (ID_SPACE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res_space (!res_full),
    .res_push  (res_push),
    .res       (res),
    .sweeping  (sweeping)
  );

  tgq_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

>>> hdl/tgq_front.sv
`default_nettype none

module tgq_front
  import tgq_pkg::*;
#(
  parameter int ID_SPACE   = ID_SPACE_DEF,
  parameter int TEAM_COUNT = TEAM_COUNT_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output cmd_t  cmd,
  output logic  cmd_valid,
  input  logic  cmd_pop
);

  localparam int PW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(BUF_DEPTH - 1);

  cmd_t          buffer [BUF_DEPTH];
  cmd_t          cmd_in;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    cmd_in.mode        = item.mode;
    cmd_in.element_id  = item.element_id;
    cmd_in.team_number = item.team_number;
    cmd_in.id_ok       = id_in_space(item.element_id, ID_SPACE);
    cmd_in.load_ok     = cmd_in.id_ok && (int'(item.team_number) < TEAM_COUNT);
  end

  assign full      = (count == CW'(BUF_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = buffer[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      buffer[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/tgq_resq.sv
`default_nettype none

module tgq_resq
  import tgq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res,
  output logic    res_full,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam int PW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(BUF_DEPTH - 1);

  result_t       buffer [BUF_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign res_full = (count == CW'(BUF_DEPTH));
  assign empty    = (count == '0);
  assign result   = buffer[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      buffer[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/tgq_back.sv
`default_nettype none

module tgq_back
  import tgq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_SPACE    = ID_SPACE_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  logic    cmd_valid,
  output logic    cmd_pop,
  input  logic    res_space,
  output logic    res_push,
  output result_t res,
  output logic    sweeping
);

  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int QA = $clog2(QUEUE_DEPTH);
  localparam int AW = $clog2(ID_SPACE);
  localparam logic [AW-1:0] SWEEP_LAST = AW'(ID_SPACE - 1);
  localparam logic [OW-1:0] OCC_FULL   = OW'(QUEUE_DEPTH);

  localparam logic [3:0] S_SWEEP  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EQ0    = 4'd2;
  localparam logic [3:0] S_EQ1    = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SHIFT  = 4'd5;
  localparam logic [3:0] S_PLACE  = 4'd6;
  localparam logic [3:0] S_DEQ0   = 4'd7;
  localparam logic [3:0] S_DEQ1   = 4'd8;
  localparam logic [3:0] S_DSHIFT = 4'd9;

  function automatic logic [AW-1:0] tt_addr(input logic [ID_W-1:0] id);
    logic [31:0] wide;
    wide = 32'(id);
    return wide[AW-1:0];
  endfunction

  logic [TEAM_W-1:0] team_table [ID_SPACE];
  logic [ID_W-1:0]   queue_store [QUEUE_DEPTH];

  logic              tt_we;
  logic [AW-1:0]     tt_waddr;
  logic [TEAM_W-1:0] tt_wdata;
  logic [AW-1:0]     tt_raddr;
  logic [TEAM_W-1:0] tt_rdata;
  logic              qs_we;
  logic [QA-1:0]     qs_waddr;
  logic [ID_W-1:0]   qs_wdata;
  logic [QA-1:0]     qs_raddr;
  logic [ID_W-1:0]   qs_rdata;

  logic [3:0]        state, state_next;
  logic [OW-1:0]     occ, occ_next;
  logic [OW-1:0]     idx, idx_next;
  logic [OW-1:0]     rem, rem_next;
  logic [OW-1:0]     pos, pos_next;
  logic              found, found_next;
  logic [TEAM_W-1:0] mine, mine_next;
  logic              s1_v, s1_v_next;
  logic [OW-1:0]     s1_idx, s1_idx_next;
  logic              s2_v, s2_v_next;
  logic [OW-1:0]     s2_idx, s2_idx_next;
  logic              s2_inr, s2_inr_next;
  logic              w_v, w_v_next;
  logic [QA-1:0]     w_addr, w_addr_next;
  logic [ID_W-1:0]   head, head_next;
  cmd_t              cur, cur_next;
  logic [AW-1:0]     sweep, sweep_next;

  logic [TEAM_W-1:0] team_e;
  logic [OW-1:0]     idx_dec;
  logic [OW-1:0]     occ_inc;
  logic [OW-1:0]     occ_dec;
  logic              scan_stop;
  logic [OW-1:0]     stop_pos;

  assign team_e   = s2_inr ? tt_rdata : '0;
  assign idx_dec  = idx - OW'(1);
  assign occ_inc  = occ + OW'(1);
  assign occ_dec  = occ - OW'(1);
  assign sweeping = (state == S_SWEEP);

  always_ff @(posedge clk) begin
    if (tt_we) begin
      team_table[tt_waddr] <= tt_wdata;
    end
    tt_rdata <= team_table[tt_raddr];
  end

  always_ff @(posedge clk) begin
    if (qs_we) begin
      queue_store[qs_waddr] <= qs_wdata;
    end
    qs_rdata <= queue_store[qs_raddr];
  end

  always_comb begin
    state_next  = state;
    occ_next    = occ;
    idx_next    = idx;
    rem_next    = rem;
    pos_next    = pos;
    found_next  = found;
    mine_next   = mine;
    s1_v_next   = 1'b0;
    s1_idx_next = idx;
    s2_v_next   = s1_v;
    s2_idx_next = s1_idx;
    s2_inr_next = id_in_space(qs_rdata, ID_SPACE);
    w_v_next    = 1'b0;
    w_addr_next = w_addr;
    head_next   = head;
    cur_next    = cur;
    sweep_next  = sweep;
    scan_stop   = 1'b0;
    stop_pos    = occ;

    tt_raddr = tt_addr(qs_rdata);
    tt_we    = 1'b0;
    tt_waddr = tt_addr(cmd.element_id);
    tt_wdata = cmd.team_number;
    qs_raddr = '0;
    qs_we    = w_v;
    qs_waddr = w_addr;
    qs_wdata = qs_rdata;

    cmd_pop          = 1'b0;
    res_push         = 1'b0;
    res.head_element = '0;
    res.head_valid   = 1'b0;
    res.status       = STATUS_OK;
    res.queue_count  = QCOUNT_W'(occ);

    unique case (state)
      S_SWEEP: begin
        tt_we    = 1'b1;
        tt_waddr = sweep;
        tt_wdata = '0;
        if (sweep == SWEEP_LAST) begin
          state_next = S_IDLE;
        end else begin
          sweep_next = sweep + AW'(1);
        end
      end
      S_IDLE: begin
        if (cmd_valid && res_space) begin
          cmd_pop  = 1'b1;
          cur_next = cmd;
          unique case (cmd.mode)
            MODE_LOAD: begin
              tt_we    = cmd.load_ok;
              res_push = 1'b1;
            end
            MODE_ENQ: begin
              if (occ == OCC_FULL) begin
                res_push   = 1'b1;
                res.status = STATUS_FULL;
              end else begin
                state_next = S_EQ0;
              end
            end
            MODE_DEQ: begin
              if (occ == '0) begin
                res_push   = 1'b1;
                res.status = STATUS_EMPTY;
              end else begin
                state_next = S_DEQ0;
              end
            end
            MODE_CLEAR: begin
              res_push        = 1'b1;
              res.queue_count = '0;
              occ_next        = '0;
              sweep_next      = '0;
              state_next      = S_SWEEP;
            end
          endcase
        end
      end
      S_EQ0: begin
        tt_raddr   = tt_addr(cur.element_id);
        state_next = S_EQ1;
      end
      S_EQ1: begin
        mine_next  = cur.id_ok ? tt_rdata : '0;
        found_next = 1'b0;
        idx_next   = '0;
        if (occ == '0) begin
          pos_next   = '0;
          rem_next   = '0;
          state_next = S_SHIFT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx < occ) begin
          qs_raddr  = idx[QA-1:0];
          s1_v_next = 1'b1;
          idx_next  = idx + OW'(1);
        end
        if (s2_v) begin
          if ((team_e != mine) && found) begin
            scan_stop = 1'b1;
            stop_pos  = s2_idx;
          end else if (s2_idx == occ_dec) begin
            scan_stop = 1'b1;
            stop_pos  = occ;
          end
          found_next = found || (team_e == mine);
        end
        if (scan_stop) begin
          s1_v_next  = 1'b0;
          s2_v_next  = 1'b0;
          pos_next   = stop_pos;
          rem_next   = occ - stop_pos;
          idx_next   = occ;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (rem != '0) begin
          qs_raddr    = idx_dec[QA-1:0];
          w_v_next    = 1'b1;
          w_addr_next = idx[QA-1:0];
          idx_next    = idx_dec;
          rem_next    = rem - OW'(1);
        end else if (!w_v) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        qs_we           = 1'b1;
        qs_waddr        = pos[QA-1:0];
        qs_wdata        = cur.element_id;
        occ_next        = occ_inc;
        res_push        = 1'b1;
        res.queue_count = QCOUNT_W'(occ_inc);
        state_next      = S_IDLE;
      end
      S_DEQ0: begin
        qs_raddr   = '0;
        state_next = S_DEQ1;
      end
      S_DEQ1: begin
        head_next  = qs_rdata;
        idx_next   = OW'(1);
        state_next = S_DSHIFT;
      end
      S_DSHIFT: begin
        if (idx < occ) begin
          qs_raddr    = idx[QA-1:0];
          w_v_next    = 1'b1;
          w_addr_next = idx_dec[QA-1:0];
          idx_next    = idx + OW'(1);
        end else if (!w_v) begin
          res_push         = 1'b1;
          res.head_element = head;
          res.head_valid   = 1'b1;
          res.queue_count  = QCOUNT_W'(occ_dec);
          occ_next         = occ_dec;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      occ   <= '0;
      sweep <= '0;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      w_v   <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      sweep <= sweep_next;
      s1_v  <= s1_v_next;
      s2_v  <= s2_v_next;
      w_v   <= w_v_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    rem    <= rem_next;
    pos    <= pos_next;
    found  <= found_next;
    mine   <= mine_next;
    s1_idx <= s1_idx_next;
    s2_idx <= s2_idx_next;
    s2_inr <= s2_inr_next;
    w_addr <= w_addr_next;
    head   <= head_next;
    cur    <= cur_next;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_FULL)
    else $error("Queue occupancy exceeds its capacity.");

  a_res_space: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_space)
    else $error("Result written while the result queue is full.");

  a_move_state: assert property (@(posedge clk) disable iff (rst)
    w_v |-> (state == S_SHIFT || state == S_DSHIFT))
    else $error("Pending entry move outside a shift.");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == S_IDLE && cmd_valid))
    else $error("Request taken while the back end is busy.");

  a_place_grow: assert property (@(posedge clk) disable iff (rst)
    state == S_PLACE |=> occ == $past(occ) + OW'(1))
    else $error("Enqueue did not grow the queue by one.");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`default_nettype none

module tb_top
  import tgq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 752;
  localparam int SEGMENT      = 94;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int POOL_SIZE    = 16;

  typedef struct {
    item_t   req;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    full;
  item_t   item = '0;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;

  bit      drv_typed = 1'b0;
  result_t drv_want = '0;

  logic [TEAM_W-1:0] team_map [ID_SPACE_DEF];
  logic [ID_W-1:0]   line [QUEUE_DEPTH_DEF];
  int                line_len = 0;

  result_t  awaited_results [$];
  dir_row_t directed_rows [$];
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  int items_accepted = 0;
  int failures = 0;
  int cycle_count = 0;
  int tx_idle = 38;
  int rx_idle = 62;

  team_grouped_queue_top dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[team_grouped_queue_top] ERROR");
      $finish;
    end
  end

  function automatic result_t next_team_queue_result(input item_t req);
    result_t r;
    logic [TEAM_W-1:0] own;
    int i;
    int hit;
    int slot;
    r = '0;
    case (req.mode)
      MODE_LOAD: begin
        team_map[req.element_id] = req.team_number;
      end
      MODE_ENQ: begin
        if (line_len >= QUEUE_DEPTH_DEF) begin
          r.status = STATUS_FULL;
        end else begin
          own = team_map[req.element_id];
          hit = -1;
          for (i = 0; i < line_len && hit < 0; i++)
            if (team_map[line[i]] == own) hit = i;
          slot = line_len;
          if (hit >= 0) begin
            slot = hit;
            while (slot < line_len && team_map[line[slot]] == own) slot++;
          end
          for (i = line_len; i > slot; i--) line[i] = line[i-1];
          line[slot] = req.element_id;
          line_len++;
        end
      end
      MODE_DEQ: begin
        if (line_len == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.head_element = line[0];
          r.head_valid = 1'b1;
          for (i = 1; i < line_len; i++) line[i-1] = line[i];
          line_len--;
        end
      end
      default: begin
        for (i = 0; i < ID_SPACE_DEF; i++) team_map[i] = '0;
        line_len = 0;
      end
    endcase
    r.status = r.status;
    r.queue_count = QCOUNT_W'(line_len);
    return r;
  endfunction

  function automatic void note_failure(input string what, input result_t want,
                                       input result_t got);
    failures++;
    if (failures <= 10)
      $display("%s: expected head %0d valid %0d status %0d count %0d, got %0d %0d %0d %0d",
               what, want.head_element, want.head_valid, want.status, want.queue_count,
               got.head_element, got.head_valid, got.status, got.queue_count);
  endfunction

  always @(posedge clk) begin
    result_t predicted;
    result_t want;
    if (!rst) begin
      if (push && !full) begin
        predicted = next_team_queue_result(item);
        awaited_results.push_back(drv_typed ? drv_want : predicted);
        items_accepted++;
      end
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          note_failure("Unexpected result", '0, result);
        end else begin
          want = awaited_results.pop_front();
          if (result.head_element !== want.head_element ||
              result.head_valid !== want.head_valid ||
              result.status !== want.status ||
              result.queue_count !== want.queue_count)
            note_failure("Result mismatch", want, result);
        end
      end
    end
  end

  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && items_accepted >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  function automatic dir_row_t plain(input logic [MODE_W-1:0] m, input int id, input int team);
    dir_row_t row;
    row.req = '{mode: m, element_id: ID_W'(id), team_number: TEAM_W'(team)};
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t known(input logic [MODE_W-1:0] m, input int id, input int team,
                                     input logic [STATUS_W-1:0] st, input int count);
    dir_row_t row;
    row = plain(m, id, team);
    row.typed = 1'b1;
    row.want = '{head_element: '0, head_valid: 1'b0, status: st,
                 queue_count: QCOUNT_W'(count)};
    return row;
  endfunction

  function automatic item_t random_request(input bit filling);
    item_t req;
    int p;
    p = $urandom_range(0, 99);
    req.element_id = ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, POOL_SIZE-1)]
                                                 : ID_W'($urandom_range(0, 1023));
    req.team_number = ($urandom_range(0, 4) == 0) ? TEAM_W'($urandom_range(0, 255))
                                                  : TEAM_W'($urandom_range(0, 5));
    if (filling)
      req.mode = (p < 8) ? MODE_LOAD : (p < 95) ? MODE_ENQ : MODE_DEQ;
    else
      req.mode = (p < 8) ? MODE_LOAD : (p < 16) ? MODE_ENQ : (p < 98) ? MODE_DEQ : MODE_CLEAR;
    return req;
  endfunction

  task automatic offer(input item_t req, input bit typed, input result_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= req;
    drv_typed <= typed;
    drv_want <= want;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic await_drain();
    @(negedge clk);
    push <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    for (n = 0; n < ID_SPACE_DEF; n++) team_map[n] = '0;
    for (n = 0; n < POOL_SIZE; n++) id_pool[n] = ID_W'($urandom_range(0, 1023));

    // Members of a team stay adjacent until a reload moves one of them to another team.
    directed_rows.push_back(known(MODE_DEQ,      0,   0, STATUS_EMPTY, 0));
    directed_rows.push_back(known(MODE_LOAD,     0, 255, STATUS_OK,    0));
    directed_rows.push_back(known(MODE_LOAD,  1023,   0, STATUS_OK,    0));
    directed_rows.push_back(plain(MODE_LOAD,     5,   1));
    directed_rows.push_back(plain(MODE_LOAD,     6,   1));
    directed_rows.push_back(plain(MODE_LOAD,     7,   2));
    directed_rows.push_back(known(MODE_ENQ,   1023,   0, STATUS_OK,    1));
    directed_rows.push_back(plain(MODE_ENQ,      5,   0));
    directed_rows.push_back(plain(MODE_ENQ,      7, 255));
    directed_rows.push_back(plain(MODE_ENQ,      6,   0));
    directed_rows.push_back(plain(MODE_ENQ,      0,   0));
    directed_rows.push_back(plain(MODE_ENQ,    500, 170));
    directed_rows.push_back(plain(MODE_LOAD,     7,   1));
    directed_rows.push_back(plain(MODE_LOAD,   341,   1));
    directed_rows.push_back(plain(MODE_ENQ,    341,  85));
    directed_rows.push_back(plain(MODE_DEQ,      0,   0));
    directed_rows.push_back(plain(MODE_DEQ,   1023, 255));
    directed_rows.push_back(known(MODE_CLEAR,  682,  85, STATUS_OK,    0));
    directed_rows.push_back(known(MODE_DEQ,      0,   0, STATUS_EMPTY, 0));
    directed_rows.push_back(plain(MODE_ENQ,      5,   0));
    directed_rows.push_back(plain(MODE_LOAD,   682,  85));
    directed_rows.push_back(plain(MODE_DEQ,      0,   0));

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      offer(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
    await_drain();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        await_drain();
        tx_idle = 62;
        rx_idle = 38;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        await_drain();
        tx_idle = 0;
        rx_idle = 0;
      end
      offer(random_request((n / SEGMENT) % 2 == 0), 1'b0, '0);
    end

    await_drain();
    repeat (200) @(posedge clk);
    if (awaited_results.size() != 0) note_failure("Result missing", awaited_results[0], '0);
    if (failures == 0)
      $display("[team_grouped_queue_top] OK");
    else
      $display("[team_grouped_queue_top] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/tgq_pkg.sv
hdl/tgq_front.sv
hdl/tgq_resq.sv
hdl/tgq_back.sv
hdl/team_grouped_queue_top.sv
test/tb_top.sv
